### design/p16f_pkg.sv
// shared types and constants for the posit16 es=1 floor pipeline
// used by every stage module and by the top level; depends on nothing

package p16f_pkg;

    // bit patterns of special posit values
    localparam logic [15:0] NAR_PATTERN   = 16'h8000;
    localparam logic [15:0] ONE_PATTERN   = 16'h4000;
    localparam logic [15:0] TWO_PATTERN   = 16'h5000;
    localparam logic [15:0] THREE_PATTERN = 16'h5800;
    localparam logic [15:0] BIG_PATTERN   = 16'h7C00;

    // regime run starts at this bit, exponent bit follows the terminator
    localparam int REGIME_TOP = 13;
    localparam int REGIME_LEN = 13;
    localparam int RUN_W      = 4;

    // how stage three builds the result
    localparam logic [1:0] KIND_PASS   = 2'd0;
    localparam logic [1:0] KIND_DIRECT = 2'd1;
    localparam logic [1:0] KIND_CALC   = 2'd2;

    // classified operand after stage one
    typedef struct packed {
        logic [1:0]  kind;
        logic        neg;
        logic [15:0] operand;
        logic [15:0] mag;
        logic [15:0] res;
    } class_t;

    // classified operand plus integer lsb after stage two
    typedef struct packed {
        class_t      cls;
        logic        lsb_ok;
        logic [15:0] lsb;
    } scan_t;

endpackage

### design/posit16_floor_core.sv
// top level of the posit16 es=1 floor unit
// depends on p16f_pkg, p16f_classify, p16f_scan and p16f_round
//
// usage:
//   s_axis carries one operand request per handshake, m_axis one floored
//   result per operand, in the same order.
//   the three register stages (classify, regime scan, round and sign
//   restore) load in that order; the result shows on m_axis_tvalid once
//   the round stage register holds it.
//   throughput is one request per cycle while m_axis_tready stays high.
//   when the receiver stalls, each stage holds its request and fills the
//   empty stages behind it; once all three are full, s_axis_tready drops.
//   nothing is lost or repeated across a stall.
//   reset empties the pipeline; no result is shown until a new request is
//   accepted. the unit keeps no state between requests.

module posit16_floor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] operand
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] floored
);

    logic             cls_valid;
    logic             cls_ready;
    p16f_pkg::class_t cls_data;
    logic             scan_valid;
    logic             scan_ready;
    p16f_pkg::scan_t  scan_data;

    // stage one
    p16f_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .operand   (s_axis_tdata),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    // stage two
    p16f_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (scan_valid),
        .out_ready (scan_ready),
        .out_data  (scan_data)
    );

    // stage three, drives the output channel
    p16f_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (scan_valid),
        .in_ready  (scan_ready),
        .in_data   (scan_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .floored   (m_axis_tdata)
    );

endmodule

### design/p16f_classify.sv
// stage one: magnitude, special cases and small direct results
// depends on p16f_pkg

module p16f_classify (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       operand,
    output logic              out_valid,
    input  logic              out_ready,
    output p16f_pkg::class_t  out_data
);

    logic             valid_reg;
    logic             valid_next;
    p16f_pkg::class_t data_reg;
    p16f_pkg::class_t data_next;
    logic             neg;
    logic [15:0]      mag;

    // stage accepts when empty or when its request moves on
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // sign and magnitude
    assign neg = operand > p16f_pkg::NAR_PATTERN;
    assign mag = neg ? (16'd0 - operand) : operand;

    // classify
    always_comb
    begin
        data_next.neg     = neg;
        data_next.operand = operand;
        data_next.mag     = mag;
        data_next.res     = 16'd0;
        data_next.kind    = p16f_pkg::KIND_DIRECT;
        if (operand == p16f_pkg::NAR_PATTERN)
        begin
            data_next.kind = p16f_pkg::KIND_PASS;
        end
        else if (mag < p16f_pkg::ONE_PATTERN)
        begin
            data_next.res = (neg && mag != 16'd0) ? p16f_pkg::ONE_PATTERN : 16'd0;
        end
        else if (mag < p16f_pkg::TWO_PATTERN)
        begin
            data_next.res = (neg && mag != p16f_pkg::ONE_PATTERN) ?
                            p16f_pkg::TWO_PATTERN : p16f_pkg::ONE_PATTERN;
        end
        else if (mag < p16f_pkg::THREE_PATTERN)
        begin
            data_next.res = (neg && mag != p16f_pkg::TWO_PATTERN) ?
                            p16f_pkg::THREE_PATTERN : p16f_pkg::TWO_PATTERN;
        end
        else if (mag >= p16f_pkg::BIG_PATTERN)
        begin
            data_next.kind = p16f_pkg::KIND_PASS;
        end
        else
        begin
            data_next.kind = p16f_pkg::KIND_CALC;
        end
    end

    // valid update
    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/p16f_scan.sv
// stage two: regime run priority encoder and integer lsb position
// depends on p16f_pkg

module p16f_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  p16f_pkg::class_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output p16f_pkg::scan_t   out_data
);

    logic                          valid_reg;
    logic                          valid_next;
    p16f_pkg::scan_t               data_reg;
    p16f_pkg::scan_t               data_next;
    logic [p16f_pkg::RUN_W-1:0]    run;
    logic                          run_open;
    logic                          exp_bit;
    logic [5:0]                    shift;
    logic [5:0]                    shift_cl;
    logic signed [6:0]             pos;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // count ones from the top regime bit down to the first zero
    always_comb
    begin
        run      = '0;
        run_open = 1'b1;
        for (int i = 0; i < p16f_pkg::REGIME_LEN; i++)
        begin
            if (run_open && in_data.mag[4'(p16f_pkg::REGIME_TOP - i)])
            begin
                run = run + 1'b1;
            end
            else
            begin
                run_open = 1'b0;
            end
        end
    end

    // exponent bit sits just past the terminating regime bit
    always_comb
    begin
        exp_bit = 1'b0;
        if (run < p16f_pkg::RUN_W'(p16f_pkg::REGIME_TOP))
        begin
            exp_bit = in_data.mag[4'(p16f_pkg::REGIME_TOP - 1) - run];
        end
    end

    // integer lsb lies shift bits below the exponent bit position
    assign shift    = {1'b0, run, 1'b0} + {5'd0, exp_bit};
    assign shift_cl = (shift > 6'd15) ? 6'd15 : shift;
    assign pos      = 7'sd12 - $signed({3'd0, run}) - $signed({1'b0, shift_cl});

    always_comb
    begin
        data_next.cls    = in_data;
        data_next.lsb_ok = (run < p16f_pkg::RUN_W'(p16f_pkg::REGIME_TOP)) && (pos >= 7'sd0);
        data_next.lsb    = 16'd1 << pos[3:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### design/p16f_round.sv
// stage three: clear fraction bits, bump negatives, restore sign
// depends on p16f_pkg; its register is the output register of the block

module p16f_round (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  p16f_pkg::scan_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       floored
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] floored_reg;
    logic [15:0] floored_next;
    logic [15:0] mask;
    logic        dropped;
    logic [15:0] kept;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign floored   = floored_reg;

    // truncate below the integer lsb, one unit more for negatives that lost bits
    assign mask    = in_data.lsb - 16'd1;
    assign dropped = |(in_data.cls.mag & mask);

    always_comb
    begin
        kept = in_data.cls.mag;
        if (in_data.lsb_ok)
        begin
            kept = (in_data.cls.mag & ~mask) +
                   ((in_data.cls.neg && dropped) ? in_data.lsb : 16'd0);
        end
    end

    // select result and restore sign
    always_comb
    begin
        case (in_data.cls.kind)
            p16f_pkg::KIND_PASS:
            begin
                floored_next = in_data.cls.operand;
            end
            p16f_pkg::KIND_DIRECT:
            begin
                floored_next = in_data.cls.neg ? (16'd0 - in_data.cls.res) : in_data.cls.res;
            end
            p16f_pkg::KIND_CALC:
            begin
                floored_next = in_data.cls.neg ? (16'd0 - kept) : kept;
            end
            default:
            begin
                floored_next = in_data.cls.operand;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            floored_reg <= floored_next;
        end
    end

endmodule

### design/p16f_checker.sv
// port-level checks for posit16_floor_core
// bound to the top level; depends on its port list only

module p16f_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // nar flows through unchanged when the receiver keeps taking
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_axis_tvalid && s_axis_tready && s_axis_tdata == 16'h8000, 3) &&
        $past(m_axis_tready, 2) && $past(m_axis_tready, 1)
        |-> m_axis_tvalid && m_axis_tdata == 16'h8000)
        else $error("nar not passed through");

    // zero floors to zero when the receiver keeps taking
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_axis_tvalid && s_axis_tready && s_axis_tdata == 16'h0000, 3) &&
        $past(m_axis_tready, 2) && $past(m_axis_tready, 1)
        |-> m_axis_tvalid && m_axis_tdata == 16'h0000)
        else $error("zero not floored to zero");

endmodule

bind posit16_floor_core p16f_checker u_p16f_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
